@@ rtl/sync_length_frame_deframer_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame deframer modules
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("slfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("slfd assertion failed");

`endif

@@ rtl/slfd_pkg.sv @@
// ---------------------------------------------------------------------------
// slfd_pkg
// Types and constants shared by the sync/length frame deframer.
// ---------------------------------------------------------------------------
package slfd_pkg;

	// header and trailer sizes in bytes
	localparam int unsigned HDR_BYTES = 12;
	localparam int unsigned END_BYTES = 4;

	// register reset values
	localparam logic [31:0] SYNC_WORD_RST   = 32'h1234_5678;
	localparam logic [31:0] END_WORD_RST    = 32'h8765_4321;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd12783;
	localparam logic [31:0] ACK_TYPE_A_RST  = 32'd0;
	localparam logic [31:0] ACK_TYPE_B_RST  = 32'd1;

	// register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_WORD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE_A  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE_B  = 3'd4;

	typedef enum logic [2:0] {
		EV_DATA     = 3'd0,
		EV_GOOD     = 3'd1,
		EV_BADEND   = 3'd2,
		EV_SYNCERR  = 3'd3,
		EV_ACK      = 3'd4,
		EV_OVERSIZE = 3'd5
	} ev_kind_t;

	typedef struct packed {
		logic [31:0] sync_word;
		logic [31:0] end_word;
		logic [15:0] max_payload;
		logic [31:0] ack_type_a;
		logic [31:0] ack_type_b;
	} cfg_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [31:0] frame_kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_length;
	} ev_t;

	// length word saturated to 16 bits
	function automatic logic [15:0] sat_len(input logic [31:0] len);
		sat_len = (|len[31:16]) ? 16'hFFFF : len[15:0];
	endfunction

endpackage

@@ rtl/slfd_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// slfd_cfg_regs
// Configuration register file; every write is taken at once.
// ---------------------------------------------------------------------------
module slfd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [slfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output slfd_pkg::cfg_t                 cfg
);

	slfd_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word   <= slfd_pkg::SYNC_WORD_RST;
			cfg_q.end_word    <= slfd_pkg::END_WORD_RST;
			cfg_q.max_payload <= slfd_pkg::MAX_PAYLOAD_RST;
			cfg_q.ack_type_a  <= slfd_pkg::ACK_TYPE_A_RST;
			cfg_q.ack_type_b  <= slfd_pkg::ACK_TYPE_B_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				slfd_pkg::REG_SYNC_WORD:   cfg_q.sync_word   <= cfg_data;
				slfd_pkg::REG_END_WORD:    cfg_q.end_word    <= cfg_data;
				slfd_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data[15:0];
				slfd_pkg::REG_ACK_TYPE_A:  cfg_q.ack_type_a  <= cfg_data;
				slfd_pkg::REG_ACK_TYPE_B:  cfg_q.ack_type_b  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/slfd_core.sv @@
// ---------------------------------------------------------------------------
// slfd_core
// Input byte register and frame parser: header capture, payload pass-through
// and end word check, one byte per cycle while the output buffer has room.
// ---------------------------------------------------------------------------
`include "sync_length_frame_deframer_macros.svh"

module slfd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rx_valid,
	output logic           rx_stall,
	input  logic [7:0]     rx_byte,
	input  slfd_pkg::cfg_t cfg,
	input  logic           space,
	output logic           ev_push,
	output slfd_pkg::ev_t  ev
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_END     = 2'd2
	} phase_t;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	phase_t      phase_q, phase_n;
	logic [15:0] count_q, count_n, count_inc;
	logic [31:0] sync_q, type_q, len_q, endw_q;
	logic [31:0] sync_u, type_u, len_u, endw_u;
	logic [31:0] lane_word;
	logic        fire, clear, emit;
	slfd_pkg::ev_kind_t kind;

	// the byte in s1 is parsed once the output buffer has room
	assign fire     = valid_s1 && space;
	assign rx_stall = valid_s1 && !space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// byte placed at its little-endian lane within a 32-bit word
	assign lane_word = 32'(byte_s1) << {count_q[1:0], 3'b000};
	assign count_inc = count_q + 16'd1;

	// parse step
	always_comb begin
		sync_u  = sync_q;
		type_u  = type_q;
		len_u   = len_q;
		endw_u  = endw_q;
		phase_n = phase_q;
		count_n = count_inc;
		clear   = 1'b0;
		emit    = 1'b0;
		kind    = slfd_pkg::EV_DATA;
		case (phase_q)
			PH_PAYLOAD: begin
				emit = 1'b1;
				if ({16'd0, count_inc} >= len_q) begin
					phase_n = PH_END;
					count_n = '0;
				end
			end
			PH_END: begin
				endw_u = endw_q | lane_word;
				if (count_q == 16'(slfd_pkg::END_BYTES - 1)) begin
					emit  = 1'b1;
					clear = 1'b1;
					kind  = (endw_u == cfg.end_word) ? slfd_pkg::EV_GOOD
					                                 : slfd_pkg::EV_BADEND;
				end
			end
			default: begin
				// header phase, also taken for the unused phase code
				phase_n = PH_HEADER;
				if (count_q < 16'd4) begin
					sync_u = sync_q | lane_word;
				end else if (count_q < 16'd8) begin
					type_u = type_q | lane_word;
				end else begin
					len_u = len_q | lane_word;
				end
				if (count_q == 16'(slfd_pkg::HDR_BYTES - 1)) begin
					if (sync_u != cfg.sync_word) begin
						emit  = 1'b1;
						clear = 1'b1;
						kind  = slfd_pkg::EV_SYNCERR;
					end else if (type_u == cfg.ack_type_a || type_u == cfg.ack_type_b) begin
						emit  = 1'b1;
						clear = 1'b1;
						kind  = slfd_pkg::EV_ACK;
					end else if (len_u > {16'd0, cfg.max_payload}) begin
						emit  = 1'b1;
						clear = 1'b1;
						kind  = slfd_pkg::EV_OVERSIZE;
					end else begin
						count_n = '0;
						phase_n = (len_u == 32'd0) ? PH_END : PH_PAYLOAD;
					end
				end
			end
		endcase
	end

	// result word, taken from the captures after this byte
	assign ev_push           = fire && emit;
	assign ev.kind           = kind;
	assign ev.frame_kind     = type_u;
	assign ev.payload_byte   = (kind == slfd_pkg::EV_DATA) ? byte_s1 : 8'd0;
	assign ev.payload_length = slfd_pkg::sat_len(len_u);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= '0;
			sync_q  <= '0;
			type_q  <= '0;
			len_q   <= '0;
			endw_q  <= '0;
		end else if (fire) begin
			if (clear) begin
				phase_q <= PH_HEADER;
				count_q <= '0;
				sync_q  <= '0;
				type_q  <= '0;
				len_q   <= '0;
				endw_q  <= '0;
			end else begin
				phase_q <= phase_n;
				count_q <= count_n;
				sync_q  <= sync_u;
				type_q  <= type_u;
				len_q   <= len_u;
				endw_q  <= endw_u;
			end
		end
	end

	`SLFD_ASSERT_NOW(a_hdr_count, clk, arst_n, phase_q == PH_HEADER, count_q < 16'(slfd_pkg::HDR_BYTES))
	`SLFD_ASSERT_NOW(a_end_count, clk, arst_n, phase_q == PH_END, count_q < 16'(slfd_pkg::END_BYTES))
	`SLFD_ASSERT_NOW(a_data_phase, clk, arst_n, ev_push && kind == slfd_pkg::EV_DATA, phase_q == PH_PAYLOAD)

endmodule

@@ rtl/slfd_out_fifo.sv @@
// ---------------------------------------------------------------------------
// slfd_out_fifo
// Two-word result buffer: two entries with read and write pointers, so the
// parser keeps running while a result waits to be taken.
// ---------------------------------------------------------------------------
`include "sync_length_frame_deframer_macros.svh"

module slfd_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slfd_pkg::ev_t push_ev,
	output logic          space,
	output logic          ev_valid,
	input  logic          ev_stall,
	output slfd_pkg::ev_t ev
);

	slfd_pkg::ev_t entry_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          pop;

	assign space    = (count_q != 2'd2);
	assign ev_valid = (count_q != 2'd0);
	assign pop      = ev_valid && !ev_stall;
	assign ev       = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// result words
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_ev;
		end
	end

	`SLFD_ASSERT_NOW(a_no_overflow, clk, arst_n, push, count_q != 2'd2)
	`SLFD_ASSERT_NOW(a_level_range, clk, arst_n, 1'b1, count_q <= 2'd2)
	`SLFD_ASSERT_NEXT(a_push_shows, clk, arst_n, push && !pop, ev_valid)

endmodule

@@ rtl/sync_length_frame_deframer.sv @@
// ---------------------------------------------------------------------------
// sync_length_frame_deframer
// Splits a received byte stream into sync/type/length framed packets.
// ---------------------------------------------------------------------------
// One received byte is accepted every cycle while rx_stall is low. A byte is
// registered on entry (s1) and parsed from that register once the output
// buffer has room; its result (if any) is written into the buffer, whose
// head is the output. Results sit in a two-word output buffer; rx_stall rises
// only when both words are held. While every byte gives a result, downstream
// stalls fill the buffer and then hold the input.
// Header bytes 1..11 and the first three end word bytes give no result.
// The configuration port takes a write in every cycle (cfg_ready is high).
// ---------------------------------------------------------------------------
module sync_length_frame_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           ev_valid,
	input  logic                           ev_stall,
	output logic [2:0]                     event_kind,
	output logic [31:0]                    frame_kind,
	output logic [7:0]                     payload_byte,
	output logic [15:0]                    payload_length,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [slfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	slfd_pkg::cfg_t cfg;
	slfd_pkg::ev_t  core_ev, out_ev;
	logic           core_push, space;

	// configuration registers
	slfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// frame parser
	slfd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.cfg      (cfg),
		.space    (space),
		.ev_push  (core_push),
		.ev       (core_ev)
	);

	// result buffer
	slfd_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (core_push),
		.push_ev  (core_ev),
		.space    (space),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev       (out_ev)
	);

	assign event_kind     = out_ev.kind;
	assign frame_kind     = out_ev.frame_kind;
	assign payload_byte   = out_ev.payload_byte;
	assign payload_length = out_ev.payload_length;

endmodule
